@@ rtl/uesi_pkg.sv @@
// shared types and constants of the unique edge set block
`timescale 1ns / 1ps

package uesi_pkg;

    localparam int INDEX_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 9;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd3;

    // search token handed from cell to cell
    typedef struct packed {
        logic live;
        logic hit;
    } tok_t;

endpackage

@@ rtl/uesi_in_if.sv @@
// request channel of the unique edge set block
`timescale 1ns / 1ps

interface uesi_in_if;
    import uesi_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;

    modport source (output valid, action, first_index, second_index, input ready);
    modport sink   (input valid, action, first_index, second_index, output ready);
endinterface

@@ rtl/uesi_out_if.sv @@
// result channel of the unique edge set block
`timescale 1ns / 1ps

interface uesi_out_if;
    import uesi_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  low_vertex;
    logic [INDEX_W-1:0]  high_vertex;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  edge_total;

    modport source (output valid, low_vertex, high_vertex, status, edge_total, input ready);
    modport sink   (input valid, low_vertex, high_vertex, status, edge_total, output ready);
endinterface

@@ rtl/unique_edge_set_insert.sv @@
// top level of the unique edge set: control, fill count and the row of compare cells
`timescale 1ns / 1ps

// usage
//   request channel: action (0 insert, 1 clear), first_index, second_index
//   result channel: low_vertex, high_vertex, status, edge_total, one item per request
//   an insert orders its indices, then a search token walks the row of MAX_EDGES
//   cells, one cell per cycle; every cell below the fill count compares its edge,
//   and the cell at the fill count stores the pair if nothing upstream matched
//   sequence: an insert is registered at acceptance, its token passes the register
//   of every cell, then S_SEARCH moves to S_FINISH; a clear goes from S_IDLE straight
//   to S_FINISH; S_FINISH loads the output register; one item at a time: requests
//   are taken only in S_IDLE, once the previous item has left S_FINISH
//   the result sits in an output register; a new request is taken while it waits,
//   and only the final step of the next item holds until the receiver takes it
//   reset empties the set (fill count to zero); stored edges need no clearing
//   since only cells below the fill count ever compare
//   a new edge arriving with the store full is not stored and reports status full

module unique_edge_set_insert
    import uesi_pkg::*;
#(
    parameter int MAX_EDGES  = 256,
    parameter int INDEX_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    uesi_in_if.sink   request,
    uesi_out_if.source result
);

    localparam int COUNT_W = $clog2(MAX_EDGES + 1);
    localparam int KEY_W   = 2 * INDEX_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                clear_reg, clear_next;
    logic                launch_reg, launch_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_low_reg, out_low_next;
    logic [INDEX_W-1:0]  out_high_reg, out_high_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;

    // index inputs reduced to INDEX_BITS
    logic [INDEX_BITS+INDEX_W-1:0] first_ext;
    logic [INDEX_BITS+INDEX_W-1:0] second_ext;
    logic [INDEX_BITS-1:0]         idx_a;
    logic [INDEX_BITS-1:0]         idx_b;
    logic [INDEX_BITS-1:0]         ord_lo;
    logic [INDEX_BITS-1:0]         ord_hi;

    // stored pair back to the output width
    logic [INDEX_BITS+INDEX_W-1:0] lo_ext;
    logic [INDEX_BITS+INDEX_W-1:0] hi_ext;
    logic [COUNT_W+TOTAL_W-1:0]    total_ext;
    logic [COUNT_W-1:0]            count_new;
    logic [STATUS_W-1:0]           status_new;

    tok_t tok_chain [0:MAX_EDGES];
    tok_t tail_tok;

    assign first_ext  = {{INDEX_BITS{1'b0}}, request.first_index};
    assign second_ext = {{INDEX_BITS{1'b0}}, request.second_index};
    assign idx_a      = first_ext[INDEX_BITS-1:0];
    assign idx_b      = second_ext[INDEX_BITS-1:0];
    assign ord_lo     = (idx_a > idx_b) ? idx_b : idx_a;
    assign ord_hi     = (idx_a > idx_b) ? idx_a : idx_b;

    assign lo_ext     = {{INDEX_W{1'b0}}, key_reg[KEY_W-1:INDEX_BITS]};
    assign hi_ext     = {{INDEX_W{1'b0}}, key_reg[INDEX_BITS-1:0]};

    // row of compare cells, token enters at cell zero
    assign tok_chain[0].live = launch_reg;
    assign tok_chain[0].hit  = 1'b0;
    assign tail_tok          = tok_chain[MAX_EDGES];

    for (genvar g = 0; g < MAX_EDGES; g++)
    begin : g_cell
        uesi_cell #(
            .KEY_W   (KEY_W),
            .COUNT_W (COUNT_W),
            .CELL_ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (key_reg),
            .fill    (count_reg),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1])
        );
    end

    // outcome of the finished item
    always_comb
    begin
        count_new  = count_reg;
        status_new = ST_ADDED;
        if (clear_reg)
        begin
            count_new  = '0;
            status_new = ST_CLEARED;
        end
        else if (hit_reg)
        begin
            status_new = ST_DUPLICATE;
        end
        else if (count_reg < COUNT_W'(MAX_EDGES))
        begin
            count_new  = count_reg + COUNT_W'(1);
            status_new = ST_ADDED;
        end
        else
        begin
            status_new = ST_FULL;
        end
    end

    assign total_ext = {{TOTAL_W{1'b0}}, count_new};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        clear_next      = clear_reg;
        launch_next     = 1'b0;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    key_next   = {ord_lo, ord_hi};
                    clear_next = request.action;
                    hit_next   = 1'b0;
                    if (request.action)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                // token left the last cell: search is complete
                if (tail_tok.live)
                begin
                    hit_next   = tail_tok.hit;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_low_next    = clear_reg ? '0 : lo_ext[INDEX_W-1:0];
                    out_high_next   = clear_reg ? '0 : hi_ext[INDEX_W-1:0];
                    out_status_next = status_new;
                    out_total_next  = total_ext[TOTAL_W-1:0];
                    count_next      = count_new;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            key_reg        <= '0;
            clear_reg      <= 1'b0;
            launch_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_low_reg    <= '0;
            out_high_reg   <= '0;
            out_status_reg <= ST_ADDED;
            out_total_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            key_reg        <= key_next;
            clear_reg      <= clear_next;
            launch_reg     <= launch_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            out_low_reg    <= out_low_next;
            out_high_reg   <= out_high_next;
            out_status_reg <= out_status_next;
            out_total_reg  <= out_total_next;
        end
    end

    assign request.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.low_vertex  = out_low_reg;
    assign result.high_vertex = out_high_reg;
    assign result.status      = out_status_reg;
    assign result.edge_total  = out_total_reg;

`ifndef NO_ASSERTIONS
    // no token may leave the end of the row while new requests are taken
    a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !tail_tok.live)
        else $error("search token alive while idle");

    // fill count never passes the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_EDGES))
        else $error("fill count beyond store size");

    // a clear result reports an empty set
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_CLEARED)) |-> (out_total_reg == '0))
        else $error("clear result with nonzero total");

    // an added edge grows the fill count by one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && (!out_valid_reg || result.ready) && !clear_reg
         && status_new == ST_ADDED) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("added edge did not grow the fill count");
`endif

endmodule

@@ rtl/uesi_cell.sv @@
// one compare cell: holds one stored edge and forwards the search token
`timescale 1ns / 1ps

module uesi_cell
    import uesi_pkg::*;
#(
    parameter int KEY_W   = 32,
    parameter int COUNT_W = 9,
    parameter int CELL_ID = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [KEY_W-1:0]   key,
    input  logic [COUNT_W-1:0] fill,
    input  tok_t               tok_in,
    output tok_t               tok_out
);

    logic [KEY_W-1:0] entry_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             in_use;
    logic             match;
    logic             write_en;

    assign in_use   = COUNT_W'(CELL_ID) < fill;
    assign match    = in_use && (entry_reg == key);
    // first free slot takes the key when nothing upstream matched
    assign write_en = tok_in.live && !tok_in.hit && (fill == COUNT_W'(CELL_ID));

    always_comb
    begin
        tok_next.live = tok_in.live;
        tok_next.hit  = tok_in.live && (tok_in.hit || match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entry_reg <= key;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ sim/uesi_tb_pkg.sv @@
// request codes shared by the edge set testbench files
`timescale 1ns / 1ps

package uesi_tb_pkg;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

endpackage

@@ sim/edge_set_monitor.sv @@
// watches both channels of the edge set, predicts each result item and compares
`timescale 1ns / 1ps

module edge_set_monitor
    import uesi_pkg::*;
    import uesi_tb_pkg::*;
#(
    parameter int MAX_EDGES  = 256,
    parameter int INDEX_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    uesi_in_if   request,
    uesi_out_if  result,
    output int   mismatches,
    output int   outstanding
);

    localparam logic [INDEX_W-1:0] INDEX_MASK =
        (INDEX_BITS >= INDEX_W) ? {INDEX_W{1'b1}} : INDEX_W'((1 << INDEX_BITS) - 1);

    typedef struct packed {
        logic [INDEX_W-1:0] low;
        logic [INDEX_W-1:0] high;
    } edge_pair_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  low_vertex;
        logic [INDEX_W-1:0]  high_vertex;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  edge_total;
    } edge_outcome_t;

    edge_pair_t    known_edges [MAX_EDGES];
    int            known_count;
    edge_outcome_t expected_outcomes [$];

    initial mismatches = 0;
    initial outstanding = 0;

    // updates the mirrored set and returns the result the block should give
    function automatic edge_outcome_t predict_edge_outcome(input logic act,
                                                           input logic [INDEX_W-1:0] a,
                                                           input logic [INDEX_W-1:0] b);
        edge_outcome_t outcome;
        edge_pair_t    pair;
        logic [INDEX_W-1:0] ma;
        logic [INDEX_W-1:0] mb;
        logic          found;
        outcome = '0;
        if (act == ACT_CLEAR)
        begin
            known_count = 0;
            outcome.status = ST_CLEARED;
            return outcome;
        end
        ma = a & INDEX_MASK;
        mb = b & INDEX_MASK;
        pair.low  = (ma > mb) ? mb : ma;
        pair.high = (ma > mb) ? ma : mb;
        found = 1'b0;
        for (int i = 0; i < known_count; i++)
        begin
            if (known_edges[i] == pair)
                found = 1'b1;
        end
        if (found)
            outcome.status = ST_DUPLICATE;
        else if (known_count >= MAX_EDGES)
            outcome.status = ST_FULL;
        else
        begin
            known_edges[known_count] = pair;
            known_count++;
            outcome.status = ST_ADDED;
        end
        outcome.low_vertex  = pair.low;
        outcome.high_vertex = pair.high;
        outcome.edge_total  = TOTAL_W'(known_count);
        return outcome;
    endfunction

    function automatic void check_field(input string field_name,
                                        input logic [INDEX_W-1:0] want,
                                        input logic [INDEX_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        edge_outcome_t want;
        if (!rst_n)
        begin
            known_count = 0;
            expected_outcomes.delete();
        end
        else
        begin
            if (request.valid && request.ready)
                expected_outcomes.push_back(predict_edge_outcome(request.action,
                                                                 request.first_index,
                                                                 request.second_index));
            if (result.valid && result.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result item, expected none, actual %0d %0d %0d %0d",
                             $time, result.low_vertex, result.high_vertex,
                             result.status, result.edge_total);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("low_vertex", want.low_vertex, result.low_vertex);
                    check_field("high_vertex", want.high_vertex, result.high_vertex);
                    check_field("status", INDEX_W'(want.status), INDEX_W'(result.status));
                    check_field("edge_total", INDEX_W'(want.edge_total),
                                INDEX_W'(result.edge_total));
                end
            end
        end
        outstanding = expected_outcomes.size();
    end

endmodule

@@ sim/tb_top.sv @@
// top of the edge set testbench: clock, reset, request stimulus, result stalls, verdict
`timescale 1ns / 1ps

module tb_top;
    import uesi_pkg::*;
    import uesi_tb_pkg::*;

    localparam int MAX_EDGES    = 256;
    localparam int INDEX_BITS   = 16;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;

    // random part: the first stretch only inserts, enough fresh pairs to
    // overrun the store; after that clears and duplicates mix in
    localparam int RANDOM_ITEMS = 580;
    localparam int FILL_ITEMS   = 320;

    // one long receiver hold-off, counted in receiver cycles after reset
    localparam int HOLD_START  = 10000;
    localparam int HOLD_CYCLES = 800;

    // an insert walks the whole cell row, so the settle wait is sized from the row length
    localparam int SETTLE_CYCLES = MAX_EDGES + 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LIMIT_CYCLES  = 1000000;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   pending_count;

    // sender burst shaping
    int burst_left;
    int gap_left;

    uesi_in_if  request ();
    uesi_out_if result ();

    unique_edge_set_insert #(
        .MAX_EDGES  (MAX_EDGES),
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    edge_set_monitor #(
        .MAX_EDGES  (MAX_EDGES),
        .INDEX_BITS (INDEX_BITS)
    ) edge_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .result      (result),
        .mismatches  (mismatch_count),
        .outstanding (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("unique_edge_set_insert verification failed");
        $finish;
    end

    // small pool gives frequent repeats, full range exercises every index bit
    function automatic logic [INDEX_W-1:0] pick_index(input bit from_pool);
        if (from_pool)
            return INDEX_W'($urandom_range(0, 5));
        return INDEX_W'($urandom_range(0, 65535));
    endfunction

    // offers one item, called at a falling edge, returns at the falling edge
    // after acceptance; gaps between bursts drop valid and scramble the payload
    task offer_item(input logic act, input logic [INDEX_W-1:0] a,
                    input logic [INDEX_W-1:0] b);
        while (gap_left > 0)
        begin
            request.valid        = 1'b0;
            request.action       = 1'($urandom_range(0, 1));
            request.first_index  = pick_index(1'b0);
            request.second_index = pick_index(1'b0);
            gap_left--;
            @(negedge clk);
        end
        request.valid        = 1'b1;
        request.action       = act;
        request.first_index  = a;
        request.second_index = b;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    // receiver: stall pattern changes with each random-length phase, with one long hold-off
    initial
    begin
        int rx_cycle;
        int rx_mode;
        int phase_left;
        rx_cycle   = 0;
        rx_mode    = 0;
        phase_left = 0;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                result.ready = 1'b0;
            else
            begin
                if (phase_left == 0)
                begin
                    rx_mode    = $urandom_range(0, 3);
                    phase_left = $urandom_range(50, 600);
                end
                phase_left--;
                case (rx_mode)
                    0:       result.ready = 1'b1;
                    1:       result.ready = 1'($urandom_range(0, 1));
                    2:       result.ready = ($urandom_range(0, 7) != 0);
                    default: result.ready = (rx_cycle % 5 == 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int n;
        int drain;
        logic act;
        logic [INDEX_W-1:0] a;
        logic [INDEX_W-1:0] b;

        request.valid        = 1'b0;
        request.action       = ACT_INSERT;
        request.first_index  = '0;
        request.second_index = '0;
        burst_left = 0;
        gap_left   = 0;
        rst_n      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: clear on an empty set, index extremes, ordering, repeats
        offer_item(ACT_CLEAR,  16'hABCD, 16'h1234);   // clear ignores its indices
        offer_item(ACT_INSERT, 16'h0000, 16'h0000);   // equal indices, lowest
        offer_item(ACT_INSERT, 16'hFFFF, 16'hFFFF);   // equal indices, highest
        offer_item(ACT_INSERT, 16'h0000, 16'hFFFF);
        offer_item(ACT_INSERT, 16'hFFFF, 16'h0000);   // swapped copy is a duplicate
        offer_item(ACT_INSERT, 16'h0005, 16'h0003);   // needs reordering
        offer_item(ACT_INSERT, 16'h0003, 16'h0005);
        offer_item(ACT_INSERT, 16'h8000, 16'h7FFF);
        offer_item(ACT_INSERT, 16'h7FFF, 16'h8000);
        offer_item(ACT_INSERT, 16'h0001, 16'h0001);
        offer_item(ACT_INSERT, 16'hAAAA, 16'h5555);
        offer_item(ACT_INSERT, 16'h5555, 16'hAAAA);
        offer_item(ACT_CLEAR,  16'hFFFF, 16'hFFFF);
        offer_item(ACT_INSERT, 16'h0000, 16'h0000);   // stored again after the clear
        offer_item(ACT_INSERT, 16'h0000, 16'h0000);
        offer_item(ACT_INSERT, 16'h1234, 16'h1234);
        offer_item(ACT_CLEAR,  16'h0000, 16'h0000);

        // random: fill past capacity first, then mixed traffic
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < FILL_ITEMS)
            begin
                act = ACT_INSERT;
                a = pick_index($urandom_range(0, 9) == 0);
                b = pick_index(a < 6 && $urandom_range(0, 1) == 0);
            end
            else
            begin
                act = ($urandom_range(0, 29) == 0) ? ACT_CLEAR : ACT_INSERT;
                a = pick_index($urandom_range(0, 2) == 0);
                b = pick_index(a < 6 && $urandom_range(0, 3) != 0);
            end
            offer_item(act, a, b);
        end
        request.valid = 1'b0;

        // let the last results out, then give the block time to settle
        drain = 0;
        while (pending_count != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("unique_edge_set_insert verification clean");
        else
            $display("unique_edge_set_insert verification failed");
        $finish;
    end

endmodule
